### sv/homogeneous_point_transform_macros.svh
// Assertion macros shared by the point transform RTL.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge of clk, suspended while rst is high.
`define HPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("homogeneous_point_transform: assertion failed");
// Checked on every rising edge of clk, also during reset.
`define HPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("homogeneous_point_transform: assertion failed");
`else
`define HPT_ASSERT(lbl, prop)
`define HPT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/hpt_pkg.sv
// Shared constants and types of the homogeneous point transform.
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int REG_SEL_W     = $clog2(NUM_REGS);
  localparam int IDX_W         = 4;
  localparam int SUM_W         = 66;
  localparam int MAG_W         = SUM_W - 1;
  localparam int QUO_W         = 32;
  localparam int RW            = MAG_W + QUO_W;
  localparam int QUEUE_DEPTH   = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_LANES     = 3;
  localparam int COL_W         = 3;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic [MAG_W-1:0] mag_w;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic             zero_w;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### sv/homogeneous_point_transform.sv
// Top level of the homogeneous 4x4 point transform with perspective divide.
//
// Usage: each beat on the s_ channel carries one point (x, y, z) in signed
// fixed point with FRAC_BITS fraction bits. The point is multiplied as the
// row vector (x, y, z, 1) by a 4x4 matrix and the x, y and z sums are
// divided by the w sum. Each input beat yields exactly one m_ beat.
// The matrix is loaded over the cfg channel, two coefficients per 64-bit
// register; the user must load it only while no point is in flight (the block
// itself does not enforce this). cfg_ready is always high. Throughput is one
// point per cycle while m_tready stays high. A point passes three front stages
// (products, sums, sign and magnitude), the job queue, one entry stage,
// 32 divider stages that each settle one quotient bit, and the output stage.
// The restoring divider has 32 stages.
// When the receiver holds m_tready low the divider pipeline stops; the front
// end keeps accepting points until the four-entry queue fills.
// Synchronous reset loads the identity matrix and empties every stage.
`include "homogeneous_point_transform_macros.svh"

module homogeneous_point_transform #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hpt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hpt_pkg::REG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [3*hpt_pkg::COORD_W-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [3*hpt_pkg::COORD_W-1:0] m_tdata,
  // zero_divisor [0], overflowed [1]
  output logic [1:0]                  m_tuser
);

  localparam int CW = hpt_pkg::COORD_W;

  logic                   job_valid;
  hpt_pkg::job_t          job_in, job_out;
  hpt_pkg::qstat_t        qstat;
  logic                   pop;
  logic signed [CW-1:0]   ox, oy, oz;
  logic                   zdiv, ovf;

  // Registers are always writable; the user must configure only while idle (not enforced).
  assign cfg_ready = 1'b1;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .point_x   ($signed(s_tdata[CW-1:0])),
    .point_y   ($signed(s_tdata[2*CW-1:CW])),
    .point_z   ($signed(s_tdata[3*CW-1:2*CW])),
    .qstat     (qstat),
    .job_valid (job_valid),
    .job       (job_in)
  );

  hpt_queue #(.DEPTH(hpt_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_data  (job_in),
    .pop        (pop),
    .pop_data   (job_out),
    .qstat      (qstat)
  );

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .job          (job_out),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_x        (ox),
    .out_y        (oy),
    .out_z        (oz),
    .zero_divisor (zdiv),
    .overflowed   (ovf)
  );

  assign m_tdata = {oz, oy, ox};
  assign m_tuser = {ovf, zdiv};

  // A zero divisor always comes with zero coordinates and no overflow.
  `HPT_ASSERT(a_zero_div_clean, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
  // The input side only stalls because the job queue is full.
  `HPT_ASSERT(a_stall_cause, !s_tready |-> qstat.full)
  // Reset leaves no result pending once it is released.
  `HPT_ASSERT_ALWAYS(a_reset_empty, (!rst && $past(rst)) |-> !m_tvalid)

endmodule

### sv/hpt_front.sv
// Front end: coefficient registers, matrix products, sums and classification.
module hpt_front #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [hpt_pkg::IDX_W-1:0]          cfg_index,
  input  logic [hpt_pkg::REG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hpt_pkg::COORD_W-1:0] point_x,
  input  logic signed [hpt_pkg::COORD_W-1:0] point_y,
  input  logic signed [hpt_pkg::COORD_W-1:0] point_z,
  input  hpt_pkg::qstat_t                    qstat,
  output logic                               job_valid,
  output hpt_pkg::job_t                      job
);

  localparam int CW = hpt_pkg::COORD_W;
  localparam int SW = hpt_pkg::SUM_W;
  localparam int MW = hpt_pkg::MAG_W;
  localparam int NC = hpt_pkg::NUM_COLS;

  logic [hpt_pkg::REG_W-1:0] coef [hpt_pkg::NUM_REGS];

  logic en;
  logic v1, v2, v3;
  logic signed [2*CW-1:0] prod  [NC][hpt_pkg::COL_W];
  logic signed [CW-1:0]   trans [NC];
  logic signed [SW-1:0]   sum   [NC];
  logic [MW-1:0]          mag   [NC];
  logic                   neg   [NC];
  logic                   zero_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        coef[i] <= '0;
      end
      coef[0] <= hpt_pkg::REG_W'(1) << FRAC_BITS;
      coef[2] <= hpt_pkg::REG_W'(1) << (CW + FRAC_BITS);
      coef[5] <= hpt_pkg::REG_W'(1) << FRAC_BITS;
      coef[7] <= hpt_pkg::REG_W'(1) << (CW + FRAC_BITS);
    end else if (cfg_valid &&
                 cfg_index < hpt_pkg::IDX_W'(hpt_pkg::NUM_REGS)) begin
      coef[cfg_index[hpt_pkg::REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign en       = !v3 || !qstat.full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: twelve products and the four constant terms.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        prod[c][0] <= point_x * $signed(coef[2*c][CW-1:0]);
        prod[c][1] <= point_y * $signed(coef[2*c][2*CW-1:CW]);
        prod[c][2] <= point_z * $signed(coef[2*c+1][CW-1:0]);
        trans[c]   <= $signed(coef[2*c+1][2*CW-1:CW]);
      end
    end
  end

  // Stage 2: exact column sums with 2*FRAC_BITS fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        sum[c] <= SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2]) +
                  (SW'(trans[c]) <<< FRAC_BITS);
      end
    end
  end

  // Stage 3: sign and magnitude, zero divisor detection.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        neg[c] <= sum[c][SW-1];
        mag[c] <= sum[c][SW-1] ? MW'(-sum[c]) : MW'(sum[c]);
      end
      zero_w <= (sum[NC-1] == '0);
    end
  end

  assign job_valid  = v3;
  assign job.mag_x  = mag[0];
  assign job.mag_y  = mag[1];
  assign job.mag_z  = mag[2];
  assign job.mag_w  = mag[3];
  assign job.neg_x  = neg[0] ^ neg[3];
  assign job.neg_y  = neg[1] ^ neg[3];
  assign job.neg_z  = neg[2] ^ neg[3];
  assign job.zero_w = zero_w;

endmodule

### sv/hpt_queue.sv
// Short FIFO of classified jobs between the front end and the divider.
module hpt_queue #(
  parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  hpt_pkg::job_t   push_data,
  input  logic            pop,
  output hpt_pkg::job_t   pop_data,
  output hpt_pkg::qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hpt_pkg::job_t    store [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, take;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign push        = push_valid && !qstat.full;
  assign take        = pop && !qstat.empty;
  assign pop_data    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/hpt_back.sv
// Back end: bit-per-stage divider pipeline, saturation and output register.
module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hpt_pkg::qstat_t                    qstat,
  input  hpt_pkg::job_t                      job,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hpt_pkg::COORD_W-1:0] out_x,
  output logic signed [hpt_pkg::COORD_W-1:0] out_y,
  output logic signed [hpt_pkg::COORD_W-1:0] out_z,
  output logic                               zero_divisor,
  output logic                               overflowed
);

  localparam int QW = hpt_pkg::QUO_W;
  localparam int RW = hpt_pkg::RW;
  localparam int MW = hpt_pkg::MAG_W;
  localparam int NL = hpt_pkg::NUM_LANES;

  logic en;
  logic          dv    [QW+1];
  logic [MW-1:0] dw    [QW+1];
  logic          dzero [QW+1];
  logic [RW-1:0] dr    [QW+1][NL];
  logic [QW-1:0] dq    [QW+1][NL];
  logic          dneg  [QW+1][NL];
  logic          dsat  [QW+1][NL];

  logic [MW-1:0] mag_in [NL];
  logic          neg_in [NL];
  logic [RW-1:0] num_in [NL];
  logic [QW-1:0] limit  [NL];
  logic          over   [NL];
  logic [QW-1:0] qv     [NL];
  logic [QW-1:0] res    [NL];

  assign en  = !out_valid || out_ready;
  assign pop = en && !qstat.empty;

  assign mag_in[0] = job.mag_x;
  assign mag_in[1] = job.mag_y;
  assign mag_in[2] = job.mag_z;
  assign neg_in[0] = job.neg_x;
  assign neg_in[1] = job.neg_y;
  assign neg_in[2] = job.neg_z;

  // Entry stage: scale the numerator and flag quotients of 2^32 or more.
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      num_in[k] = RW'(mag_in[k]) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dw[0]    <= job.mag_w;
      dzero[0] <= job.zero_w;
      for (int k = 0; k < NL; k++) begin
        dr[0][k]   <= num_in[k];
        dq[0][k]   <= '0;
        dneg[0][k] <= neg_in[k];
        dsat[0][k] <= num_in[k] >= (RW'(job.mag_w) << QW);
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [RW-1:0] trial;
    assign trial = RW'(dw[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dw[j+1]    <= dw[j];
        dzero[j+1] <= dzero[j];
        for (int k = 0; k < NL; k++) begin
          dneg[j+1][k] <= dneg[j][k];
          dsat[j+1][k] <= dsat[j][k];
          if (dr[j][k] >= trial) begin
            dr[j+1][k] <= dr[j][k] - trial;
            dq[j+1][k] <= dq[j][k] | (QW'(1) << B);
          end else begin
            dr[j+1][k] <= dr[j][k];
            dq[j+1][k] <= dq[j][k];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      limit[k] = dneg[QW][k] ? (QW'(1) << (QW - 1)) : ~(QW'(1) << (QW - 1));
      over[k]  = dsat[QW][k] || (dq[QW][k] > limit[k]);
      qv[k]    = over[k] ? limit[k] : dq[QW][k];
      res[k]   = dzero[QW] ? '0 : (dneg[QW][k] ? -qv[k] : qv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x        <= $signed(res[0]);
      out_y        <= $signed(res[1]);
      out_z        <= $signed(res[2]);
      zero_divisor <= dzero[QW];
      overflowed   <= !dzero[QW] && (over[0] || over[1] || over[2]);
    end
  end

endmodule

### tb/sv/tb_homogeneous_point_transform.sv
// Self-checking testbench for the homogeneous 4x4 point transform with perspective divide.
module tb_homogeneous_point_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = hpt_pkg::FRAC_BITS_DEF;
  localparam int IDXW      = hpt_pkg::IDX_W;
  localparam int CRDW      = hpt_pkg::COORD_W;
  localparam int REGW      = hpt_pkg::REG_W;
  localparam int NREGS     = hpt_pkg::NUM_REGS;
  localparam int STALL_MAX = 300;   // cycles of the long receiver hold-off
  localparam int WDOG_MAX  = 5000;  // cycles with no beat at all before giving up
  localparam int LATENCY   = 37;    // pipeline depth that drain() allows for

  // Register indexes, in the order of the matrix columns.
  typedef enum logic [IDXW-1:0] {
    COL_X_LOW, COL_X_HIGH, COL_Y_LOW, COL_Y_HIGH,
    COL_Z_LOW, COL_Z_HIGH, COL_W_LOW, COL_W_HIGH
  } reg_idx_e;

  // One transformed point as the block should report it.
  typedef struct packed {
    logic [CRDW-1:0] x;
    logic [CRDW-1:0] y;
    logic [CRDW-1:0] z;
    logic            zero_div;
    logic            ovf;
  } xpoint_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDXW-1:0]        cfg_index = '0;
  logic [REGW-1:0]        cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [3*CRDW-1:0]      s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [3*CRDW-1:0]      m_tdata;
  logic [1:0]             m_tuser;

  homogeneous_point_transform #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Our own copy of the matrix registers, updated on each accepted write.
  logic [REGW-1:0]      matrix [NREGS];
  logic [3*CRDW-1:0]    points_pending [$];
  xpoint_t              points_expected [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int points_in = 0;
  int points_out = 0;
  int zero_div_seen = 0;
  int ovf_seen = 0;
  int quiet_cycles = 0;

  function automatic logic signed [127:0] coef(input logic [REGW-1:0] r, input bit upper);
    logic signed [127:0] c;
    c = upper ? $signed(r[63:32]) : $signed(r[31:0]);
    return c;
  endfunction

  // Exact column sum with 2*FRAC fraction bits; the registers sit at base and base+1.
  function automatic logic signed [127:0] column_sum(input logic signed [127:0] px,
      input logic signed [127:0] py, input logic signed [127:0] pz, input int base);
    return px * coef(matrix[base], 0) + py * coef(matrix[base], 1)
         + pz * coef(matrix[base+1], 0) + (coef(matrix[base+1], 1) <<< FRAC);
  endfunction

  // Full transform of one point: matrix product, perspective divide, saturation.
  function automatic xpoint_t transform_point(input logic [3*CRDW-1:0] d);
    logic signed [127:0] px, py, pz, w, q;
    logic signed [127:0] sums [3];
    logic [CRDW-1:0]     outs [3];
    xpoint_t r;
    px = $signed(d[31:0]);
    py = $signed(d[63:32]);
    pz = $signed(d[95:64]);
    w  = column_sum(px, py, pz, 6);
    r = '0;
    if (w == 0) begin
      r.zero_div = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      sums[k] = column_sum(px, py, pz, 2*k);
      q = (sums[k] <<< FRAC) / w;   // signed division truncates toward zero
      if (q > 128'sd2147483647) begin
        outs[k] = 32'h7FFF_FFFF;
        r.ovf = 1'b1;
      end else if (q < -128'sd2147483648) begin
        outs[k] = 32'h8000_0000;
        r.ovf = 1'b1;
      end else begin
        outs[k] = q[31:0];
      end
    end
    r.x = outs[0];
    r.y = outs[1];
    r.z = outs[2];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Sender: one beat per handshake, fed from the pending queue. The expected
  // result is computed on acceptance, with the matrix in force at that edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        points_expected.push_back(transform_point(s_tdata));
        points_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (points_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= points_pending.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random idling, plus a long hold-off on request so the divider
  // pipeline stops and the front queue fills until s_tready drops.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_served < hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= STALL_MAX;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each beat against the oldest expectation, field by field.
  always @(posedge clk) begin
    xpoint_t want;
    if (!rst && m_tvalid && m_tready) begin
      points_out++;
      if (points_expected.size() == 0) begin
        $display("[%0t] unexpected result beat %h / %b", $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = points_expected.pop_front();
        if (m_tdata[31:0] !== want.x) report("out_x", m_tdata[31:0], want.x);
        if (m_tdata[63:32] !== want.y) report("out_y", m_tdata[63:32], want.y);
        if (m_tdata[95:64] !== want.z) report("out_z", m_tdata[95:64], want.z);
        if (m_tuser[0] !== want.zero_div)
          report("zero_divisor", 32'(m_tuser[0]), 32'(want.zero_div));
        if (m_tuser[1] !== want.ovf)
          report("overflowed", 32'(m_tuser[1]), 32'(want.ovf));
        if (want.zero_div) zero_div_seen++;
        if (want.ovf) ovf_seen++;
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on any channel means a hang.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog: no beat for %0d cycles", WDOG_MAX);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [REGW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NREGS) matrix[idx] = val;   // indexes past the list are ignored
  endtask

  // Coordinates and coefficients: full range, small values, and the edges.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                        : -$urandom_range(0, 32'h0004_0000);
      3:    return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    points_pending.push_back({z, y, x});
  endtask

  // Waits until every point went in and every result came back, then lets the
  // pipeline settle before the matrix may change.
  task automatic drain();
    do @(posedge clk); while (points_pending.size() != 0 || s_tvalid || points_expected.size() != 0);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a, b;
    matrix[COL_X_LOW]  = 64'h0000_0000_0001_0000;
    matrix[COL_X_HIGH] = 64'h0;
    matrix[COL_Y_LOW]  = 64'h0001_0000_0000_0000;
    matrix[COL_Y_HIGH] = 64'h0;
    matrix[COL_Z_LOW]  = 64'h0;
    matrix[COL_Z_HIGH] = 64'h0000_0000_0001_0000;
    matrix[COL_W_LOW]  = 64'h0;
    matrix[COL_W_HIGH] = 64'h0001_0000_0000_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 10; phase++) begin
      // Idle profile: receiver-heavy gaps, then sender-heavy, then none.
      if (phase < 4) begin
        send_idle_pct = 30; recv_idle_pct = 69;
      end else if (phase < 7) begin
        send_idle_pct = 69; recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end

      case (phase)
        0: begin
          // Reset identity matrix: the point comes back unchanged, edges included.
          add_point(32'h0, 32'h0, 32'h0);
          add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
          add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        end
        1: begin
          // Extreme coefficients everywhere; also writes to unused indexes.
          for (int r = 0; r < NREGS; r++) write_reg(IDXW'(r), 64'h7FFF_FFFF_8000_0000);
          write_reg(4'd8, 64'hDEAD_BEEF_0000_0000);
          write_reg(4'd15, 64'h0);
          add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
          add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
          add_point(32'h0, 32'h0, 32'h0);
        end
        2: begin
          // w column all zero: every point hits the zero divisor.
          for (int r = 0; r < COL_W_LOW; r++) write_reg(IDXW'(r), {pick_value(), pick_value()});
          write_reg(COL_W_LOW, 64'h0);
          write_reg(COL_W_HIGH, 64'h0);
          add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        end
        3: begin
          // w = -x only, with a doubled x column: zero and negative divisors,
          // plus saturation when the x sum is large against w.
          write_reg(COL_X_LOW, 64'h0000_0000_0002_0000);
          write_reg(COL_X_HIGH, 64'h7FFF_FFFF_0000_0000);
          write_reg(COL_W_LOW, 64'h0000_0000_FFFF_0000);
          write_reg(COL_W_HIGH, 64'h0);
          add_point(32'h0, 32'h1, 32'h1);
          add_point(32'h0000_0001, 32'h0, 32'h0);
          add_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
          hold_requests = hold_requests + 1;   // long hold-off during this phase
        end
        9: begin
          // Back to the identity matrix by explicit writes.
          write_reg(COL_X_LOW, 64'h0000_0000_0001_0000);
          write_reg(COL_X_HIGH, 64'h0);
          write_reg(COL_Y_LOW, 64'h0001_0000_0000_0000);
          write_reg(COL_Y_HIGH, 64'h0);
          write_reg(COL_Z_LOW, 64'h0);
          write_reg(COL_Z_HIGH, 64'h0000_0000_0001_0000);
          write_reg(COL_W_LOW, 64'h0);
          write_reg(COL_W_HIGH, 64'h0001_0000_0000_0000);
        end
        default: begin
          // Random matrix; in some phases the x coefficient and constant term of the
          // w column are kept small so the divide amplifies and saturation shows up often.
          for (int r = 0; r < COL_W_LOW; r++) write_reg(IDXW'(r), {pick_value(), pick_value()});
          a = (phase % 2) ? $urandom_range(0, 16) : pick_value();
          b = (phase % 2) ? $urandom_range(0, 255) : pick_value();
          write_reg(COL_W_LOW, {pick_value(), a});
          write_reg(COL_W_HIGH, {b, pick_value()});
          write_reg(IDXW'($urandom_range(NREGS, 15)), {$urandom, $urandom});
        end
      endcase

      for (int n = 0; n < 48; n++) add_point(pick_value(), pick_value(), pick_value());
      drain();
    end

    $display("points in %0d, results checked %0d, over 10 matrix settings", points_in, points_out);
    $display("zero-divisor results %0d, saturated results %0d", zero_div_seen, ovf_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
